// ----- rtl/core/cdi_pkg.sv -----
`timescale 1ns / 1ps

package cdi_pkg;

  localparam int TOKEN_W = 16;
  localparam int NUM_CB  = 4;   // codebook slots carried by the payload
  localparam int SEL_W   = 2;
  localparam int DELAY_W = 4;
  localparam int FLAT_W  = 8;
  localparam int FRAME_W = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_0      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_1      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_2      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_3      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FLATTEN      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_EMPTY   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPECIAL      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_TAIL    = 3'd7;

  typedef struct packed {
    logic [TOKEN_W-1:0] token_0;
    logic [TOKEN_W-1:0] token_1;
    logic [TOKEN_W-1:0] token_2;
    logic [TOKEN_W-1:0] token_3;
    logic               last_frame;
  } in_t;

  typedef struct packed {
    logic [TOKEN_W-1:0] value_0;
    logic [TOKEN_W-1:0] value_1;
    logic [TOKEN_W-1:0] value_2;
    logic [TOKEN_W-1:0] value_3;
    logic [NUM_CB-1:0]  present;
    logic               end_of_sequence;
  } out_t;

  typedef struct packed {
    logic [NUM_CB-1:0][DELAY_W-1:0] delay;
    logic [FLAT_W-1:0]              flatten_frames;
    logic [DELAY_W-1:0]             lead_empty_steps;
    logic [TOKEN_W-1:0]             fill_token;
    logic                           drop_tail;
  } cfg_t;

  typedef enum logic [1:0] {
    STEP_EMPTY,
    STEP_FLAT,
    STEP_DELAY
  } step_kind_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LEAD,
    SEQ_MAIN,
    SEQ_TAIL
  } seq_state_t;

  // One step request from the sequencer to the lanes.
  typedef struct packed {
    logic               valid;
    step_kind_t         kind;
    logic [SEL_W-1:0]   sel;       // codebook shown by a flattened step
    logic [DELAY_W-1:0] step_ofs;  // step index minus current frame index
    logic               eos;
    logic [FRAME_W-1:0] cur;       // current frame index
  } step_t;

endpackage

// ----- rtl/core/cdi_ram.sv -----
`timescale 1ns / 1ps

module cdi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/cdi_seq.sv -----
`timescale 1ns / 1ps

module cdi_seq import cdi_pkg::*; #(
  parameter int NUM_CODEBOOKS = 4,
  parameter int RING_DEPTH    = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  cfg_t                                          regs,
  input  logic                                          in_accept,
  input  logic                                          in_last,
  input  logic                                          adv,
  output logic                                          in_stall,
  output step_t                                         step,
  output logic [(RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1)-1:0] ring_ptr
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  seq_state_t         state_r, state_nxt;
  logic [DELAY_W-1:0] cnt_r, cnt_nxt;
  logic [FRAME_W-1:0] cur_r, cur_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic               started_r, started_nxt;
  logic               last_r, last_nxt;
  logic               flat_mode_r, flat_mode_nxt;
  logic [DELAY_W-1:0] tail_cnt_r, tail_cnt_nxt;

  logic [DELAY_W-1:0] d_min, d_max;
  logic               final_step;
  logic               done;

  assign d_min = regs.delay[0];
  assign d_max = regs.delay[NUM_CODEBOOKS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SEQ_IDLE;
      cnt_r       <= '0;
      cur_r       <= '0;
      ptr_r       <= '0;
      started_r   <= 1'b0;
      last_r      <= 1'b0;
      flat_mode_r <= 1'b0;
      tail_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      ptr_r       <= ptr_nxt;
      started_r   <= started_nxt;
      last_r      <= last_nxt;
      flat_mode_r <= flat_mode_nxt;
      tail_cnt_r  <= tail_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cur_nxt       = cur_r;
    ptr_nxt       = ptr_r;
    started_nxt   = started_r;
    last_nxt      = last_r;
    flat_mode_nxt = flat_mode_r;
    tail_cnt_nxt  = tail_cnt_r;
    final_step    = 1'b0;
    done          = 1'b0;

    step          = '0;
    step.kind     = STEP_EMPTY;
    step.cur      = cur_r;
    step.sel      = cnt_r[SEL_W-1:0];

    case (state_r)
      SEQ_IDLE: begin
        if (in_accept) begin
          last_nxt      = in_last;
          flat_mode_nxt = cur_r < FRAME_W'(regs.flatten_frames);
          cnt_nxt       = '0;
          if (!in_last) begin
            tail_cnt_nxt = '0;
          end else if (regs.drop_tail && (d_max > d_min)) begin
            // only the first min-delay tail steps survive
            tail_cnt_nxt = d_min;
          end else begin
            tail_cnt_nxt = d_max;
          end
          state_nxt = started_r ? SEQ_MAIN : SEQ_LEAD;
        end
      end
      SEQ_LEAD: begin
        step.valid = adv;
        step.kind  = STEP_EMPTY;
        if (adv) begin
          if (cnt_r == regs.lead_empty_steps) begin
            cnt_nxt   = '0;
            state_nxt = SEQ_MAIN;
          end else begin
            cnt_nxt = cnt_r + DELAY_W'(1);
          end
        end
      end
      SEQ_MAIN: begin
        step.valid = adv;
        if (flat_mode_r) begin
          step.kind  = STEP_FLAT;
          final_step = cnt_r == DELAY_W'(NUM_CODEBOOKS - 1);
        end else begin
          step.kind  = STEP_DELAY;
          final_step = 1'b1;
        end
        step.eos = final_step && last_r && (tail_cnt_r == '0);
        if (adv) begin
          if (!final_step) begin
            cnt_nxt = cnt_r + DELAY_W'(1);
          end else if (tail_cnt_r == '0) begin
            done = 1'b1;
          end else begin
            cnt_nxt   = DELAY_W'(1);
            state_nxt = SEQ_TAIL;
          end
        end
      end
      SEQ_TAIL: begin
        step.valid    = adv;
        step.kind     = STEP_DELAY;
        step.step_ofs = cnt_r;
        final_step    = cnt_r == tail_cnt_r;
        step.eos      = final_step;
        if (adv) begin
          if (final_step) begin
            done = 1'b1;
          end else begin
            cnt_nxt = cnt_r + DELAY_W'(1);
          end
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase

    // frame bookkeeping moves on once every step of the frame is issued
    if (done) begin
      state_nxt   = SEQ_IDLE;
      started_nxt = !last_r;
      cur_nxt     = last_r ? '0 : cur_r + FRAME_W'(1);
      if (last_r || (cur_r == '1) || (ptr_r == AW'(RING_DEPTH - 1))) begin
        ptr_nxt = '0;
      end else begin
        ptr_nxt = ptr_r + AW'(1);
      end
    end
  end

  assign in_stall = state_r != SEQ_IDLE;
  assign ring_ptr = ptr_r;

endmodule

// ----- rtl/core/cdi_lane.sv -----
`timescale 1ns / 1ps

module cdi_lane import cdi_pkg::*; #(
  parameter int LANE       = 0,
  parameter int RING_DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [DELAY_W-1:0]                            delay,
  input  logic [FLAT_W-1:0]                             flat,
  input  step_t                                         step,
  input  logic [(RING_DEPTH > 1 ? $clog2(RING_DEPTH) : 1)-1:0] ring_ptr,
  input  logic                                          wr_en,
  input  logic [TOKEN_W-1:0]                            wr_data,
  output logic                                          pres,
  output logic [TOKEN_W-1:0]                            rdata
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW:0] DEPTH_EXT = (AW + 1)'(RING_DEPTH);

  // frame offset folded into the ring
  logic [AW-1:0] off_mod [1 << DELAY_W];

  for (genvar i = 0; i < (1 << DELAY_W); i++) begin : g_mod
    assign off_mod[i] = AW'(i % RING_DEPTH);
  end

  logic               off_ok;
  logic [DELAY_W-1:0] off;
  logic [DELAY_W-1:0] eff_off;
  logic [AW-1:0]      om;
  logic [AW-1:0]      raddr;
  logic               hit;
  logic               pres_r;

  always_comb begin
    off_ok  = delay >= step.step_ofs;
    off     = delay - step.step_ofs;
    eff_off = '0;
    hit     = 1'b0;
    case (step.kind)
      STEP_EMPTY: hit = 1'b0;
      STEP_FLAT:  hit = step.sel == SEL_W'(LANE);
      STEP_DELAY: begin
        // shown frame = cur - off must exist and lie past the flattened part
        eff_off = off;
        hit     = off_ok &&
                  ({1'b0, step.cur} >= ((FRAME_W + 1)'(flat) + (FRAME_W + 1)'(off)));
      end
      default: hit = 1'b0;
    endcase
    om = off_mod[eff_off];
    if (ring_ptr >= om) begin
      raddr = ring_ptr - om;
    end else begin
      raddr = AW'({1'b0, ring_ptr} + DEPTH_EXT - {1'b0, om});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pres_r <= 1'b0;
    end else if (step.valid) begin
      pres_r <= hit;
    end
  end

  cdi_ram #(
    .WIDTH (TOKEN_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ring_ptr),
    .wdata (wr_data),
    .re    (step.valid),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign pres = pres_r;

endmodule

// ----- rtl/core/cdi_merge.sv -----
`timescale 1ns / 1ps

module cdi_merge import cdi_pkg::*; (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_valid,
  input  logic                           step_eos,
  input  logic [NUM_CB-1:0]              pres,
  input  logic [NUM_CB-1:0][TOKEN_W-1:0] rdata,
  input  logic [TOKEN_W-1:0]             special,
  output logic                           adv,
  output logic                           out_valid,
  input  logic                           out_stall,
  output out_t                           out_data
);

  logic s1_v_r, s1_v_nxt;
  logic s1_eos_r;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r;
  out_t merged;
  logic out_free;
  logic [NUM_CB-1:0][TOKEN_W-1:0] vals;

  assign out_free = !out_valid_r || !out_stall;
  // the read stage may take a new request when it is empty or drains
  assign adv      = !s1_v_r || out_free;

  always_comb begin
    for (int q = 0; q < NUM_CB; q++) begin
      vals[q] = pres[q] ? rdata[q] : special;
    end
    merged.value_0         = vals[0];
    merged.value_1         = vals[1];
    merged.value_2         = vals[2];
    merged.value_3         = vals[3];
    merged.present         = pres;
    merged.end_of_sequence = s1_eos_r;

    s1_v_nxt      = adv ? step_valid : s1_v_r;
    out_valid_nxt = out_free ? s1_v_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_eos_r <= step_eos;
    end
    if (out_free && s1_v_r) begin
      out_data_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/core/codebook_delay_interleaver.sv -----
`timescale 1ns / 1ps

// Codebook delay interleaver: takes one frame of four codebook tokens per request and
// emits sequence steps (four values, a presence mask, end-of-sequence flag). A frame
// is taken only while no earlier frame is still issuing steps; it then issues one
// step per cycle unless the output stalls, and its step count is 1 in steady state,
// NUM_CODEBOOKS for flattened frames, plus 1 + lead_empty_steps on the first frame
// of a sequence and the tail steps on the last one. The step sequencer sets the step
// count; each codebook lane keeps its own ring of RING_DEPTH frames and reads one
// entry per step, and a step passes through the lane read register and then the
// output register. Delays of RING_DEPTH or more see the newer frame that overwrote
// the ring slot. The ring needs no clearing after reset. Delay registers are
// expected in non-decreasing order; the user must write configuration only while
// the block is idle, which the block itself does not enforce.
module codebook_delay_interleaver import cdi_pkg::*; #(
  parameter int NUM_CODEBOOKS = 4,
  parameter int RING_DEPTH    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  cfg_t          regs_r;
  logic          in_accept;
  step_t         step;
  logic [AW-1:0] ring_ptr;
  logic          adv;

  logic [NUM_CB-1:0]              pres;
  logic [NUM_CB-1:0][TOKEN_W-1:0] rdata;
  logic [NUM_CB-1:0][TOKEN_W-1:0] tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.delay            <= {4'd3, 4'd2, 4'd1, 4'd0};
      regs_r.flatten_frames   <= '0;
      regs_r.lead_empty_steps <= '0;
      regs_r.fill_token       <= '0;
      regs_r.drop_tail        <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DELAY_0:    regs_r.delay[0]            <= cfg_wdata[DELAY_W-1:0];
        REG_DELAY_1:    regs_r.delay[1]            <= cfg_wdata[DELAY_W-1:0];
        REG_DELAY_2:    regs_r.delay[2]            <= cfg_wdata[DELAY_W-1:0];
        REG_DELAY_3:    regs_r.delay[3]            <= cfg_wdata[DELAY_W-1:0];
        REG_FLATTEN:    regs_r.flatten_frames      <= cfg_wdata[FLAT_W-1:0];
        REG_LEAD_EMPTY: regs_r.lead_empty_steps    <= cfg_wdata[DELAY_W-1:0];
        REG_SPECIAL:    regs_r.fill_token          <= cfg_wdata[TOKEN_W-1:0];
        REG_DROP_TAIL:  regs_r.drop_tail           <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_accept = in_valid && !in_stall;

  assign tok[0] = in_data.token_0;
  assign tok[1] = in_data.token_1;
  assign tok[2] = in_data.token_2;
  assign tok[3] = in_data.token_3;

  cdi_seq #(
    .NUM_CODEBOOKS (NUM_CODEBOOKS),
    .RING_DEPTH    (RING_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs_r),
    .in_accept (in_accept),
    .in_last   (in_data.last_frame),
    .adv       (adv),
    .in_stall  (in_stall),
    .step      (step),
    .ring_ptr  (ring_ptr)
  );

  for (genvar q = 0; q < NUM_CB; q++) begin : g_lane
    if (q < NUM_CODEBOOKS) begin : g_on
      cdi_lane #(
        .LANE       (q),
        .RING_DEPTH (RING_DEPTH)
      ) u_lane (
        .clk      (clk),
        .rst_n    (rst_n),
        .delay    (regs_r.delay[q]),
        .flat     (regs_r.flatten_frames),
        .step     (step),
        .ring_ptr (ring_ptr),
        .wr_en    (in_accept),
        .wr_data  (tok[q]),
        .pres     (pres[q]),
        .rdata    (rdata[q])
      );
    end else begin : g_off
      assign pres[q]  = 1'b0;
      assign rdata[q] = '0;
    end
  end

  cdi_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (step.valid),
    .step_eos   (step.eos),
    .pres       (pres),
    .rdata      (rdata),
    .special    (regs_r.fill_token),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ----- rtl/core/cdi_checker.sv -----
`timescale 1ns / 1ps

module cdi_checker import cdi_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_t                  out_data
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // every frame yields at least one step, so the input closes after a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a request");

  // reset leaves no result pending and the input open
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not quiet after reset");

endmodule

bind codebook_delay_interleaver cdi_checker u_cdi_checker (.*);
